// ===== design/qwd_pkg.sv =====
// ----------------------------------------------------------------------------
// qwd_pkg
// shared types and constants of the quantized weight dequantizer
// ----------------------------------------------------------------------------
package qwd_pkg;

    localparam int LANES     = 4;
    localparam int BUF_DEPTH = 105;
    localparam int BUF_AW    = $clog2(BUF_DEPTH);

    // block layouts selected by the format register
    typedef enum logic [2:0] {
        FMT_Q4_0 = 3'd0,
        FMT_Q8_0 = 3'd1,
        FMT_Q4_K = 3'd2,
        FMT_Q5_K = 3'd3,
        FMT_Q6_K = 3'd4,
        FMT_F16  = 3'd5,
        FMT_BF16 = 3'd6,
        FMT_F32  = 3'd7
    } t_fmt;

    localparam logic [31:0] F32_DEFAULT_NAN = 32'hFFC0_0000;
    localparam logic [31:0] F32_QUIET_BIT   = 32'h0040_0000;

    typedef struct packed {
        logic [15:0] half_word;
        logic        row_end;
    } t_in;

    typedef struct packed {
        logic [31:0] lane_zero;
        logic [31:0] lane_one;
        logic [31:0] lane_two;
        logic [31:0] lane_three;
        logic [2:0]  lanes_valid;
        logic        block_last;
        logic        row_last;
    } t_out;

    // halfwords per block
    function automatic logic [6:0] block_halves(input t_fmt fmt);
        logic [6:0] n;
        unique case (fmt)
            FMT_Q4_0: n = 7'd9;
            FMT_Q8_0: n = 7'd17;
            FMT_Q4_K: n = 7'd72;
            FMT_Q5_K: n = 7'd88;
            FMT_Q6_K: n = 7'd105;
            FMT_F32:  n = 7'd2;
            default:  n = 7'd1;
        endcase
        return n;
    endfunction

endpackage

// ===== design/quantized_weight_dequantizer.sv =====
// ----------------------------------------------------------------------------
// quantized_weight_dequantizer
// gguf block stream (q4_0, q8_0, q4_k, q5_k, q6_k, f16, bf16, f32) to float32
// ----------------------------------------------------------------------------
// Halfwords of a quantized block are written into a 105 x 16 block buffer, one
// per input beat, and the block is decoded once its last halfword is in. While
// decoding, o_in_ready is low. Each value is produced by a short sequence: five
// reads of the block buffer (one byte each) followed by the shared float32
// multiplier and, for q4_k/q5_k, the shared float32 subtractor. Each block
// begins with header reads, and each output beat of a block carries four values.
// F16 and bf16 values take one input beat, f32 values take two, and each gives
// a result beat of one value. The output register frees the input side: a
// beat may be accepted while a result waits for i_out_ready. Rounding is
// round-to-nearest-even; NaN operands give the quieted first NaN, invalid
// operations give the default negative NaN.
// ----------------------------------------------------------------------------
module quantized_weight_dequantizer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_data,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  qwd_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output qwd_pkg::t_out o_out_data
);
    import qwd_pkg::*;

    localparam int LANE_IW = $clog2(LANES);
    localparam int LANE_CW = $clog2(LANES + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SINGLE,
        S_HDR,
        S_RD,
        S_OPSET,
        S_M1,
        S_M2,
        S_A1,
        S_A2,
        S_A3,
        S_LANE,
        S_OUT
    } t_state;

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------
    // half to float, denormals normalized, nan and inf kept
    function automatic logic [31:0] f_h2f(input logic [15:0] h);
        logic [4:0]  e;
        logic [9:0]  m;
        logic [3:0]  sh;
        logic [9:0]  mn;
        logic [31:0] r;
        e  = h[14:10];
        m  = h[9:0];
        sh = 4'd0;
        for (int k = 0; k < 10; k++) begin
            if (m[k]) sh = 4'(10 - k);
        end
        mn = 10'(m << sh);
        if (e == 5'd0) begin
            if (m == 10'd0) r = {h[15], 31'd0};
            else            r = {h[15], 8'd113 - {4'd0, sh}, mn, 13'd0};
        end else if (e == 5'h1F) begin
            r = {h[15], 8'hFF, m, 13'd0};
        end else begin
            r = {h[15], {3'd0, e} + 8'd112, m, 13'd0};
        end
        return r;
    endfunction

    // small signed integer to float, always exact
    function automatic logic [31:0] f_i2f(input logic signed [8:0] x);
        logic [8:0]  a;
        logic [3:0]  p;
        logic [31:0] t;
        logic [31:0] r;
        a = x[8] ? 9'(-x) : 9'(x);
        p = 4'd0;
        for (int k = 0; k < 9; k++) begin
            if (a[k]) p = 4'(k);
        end
        t = {23'd0, a} << (5'd23 - {1'b0, p});
        if (a == 9'd0) r = 32'd0;
        else           r = {x[8], 8'd127 + {4'd0, p}, t[22:0]};
        return r;
    endfunction

    // byte address of read slot for value v
    function automatic logic [7:0] f_slot(input t_fmt fmt, input logic [8:0] v,
                                          input logic [2:0] slot);
        logic [7:0] a;
        logic       kq;
        kq = (fmt == FMT_Q4_K) || (fmt == FMT_Q5_K);
        a  = 8'd0;
        case (slot)
            3'd0: begin
                case (fmt)
                    FMT_Q4_0: a = 8'd2 + {4'd0, v[3:0]};
                    FMT_Q8_0: a = 8'd2 + {3'd0, v[4:0]};
                    FMT_Q4_K: a = 8'd16 + {1'b0, v[7:6], v[4:0]};
                    FMT_Q5_K: a = 8'd48 + {1'b0, v[7:6], v[4:0]};
                    FMT_Q6_K: a = {1'b0, v[7], v[5], v[4:0]};
                    default:  a = 8'd0;
                endcase
            end
            3'd1: begin
                if (fmt == FMT_Q5_K)      a = 8'd16 + {3'd0, v[4:0]};
                else if (fmt == FMT_Q6_K) a = {2'b10, v[7], v[4:0]};
            end
            3'd2: begin
                if (kq)                   a = 8'd4 + {6'd0, v[6:5]};
                else if (fmt == FMT_Q6_K) a = 8'd192 + {4'd0, v[7], 2'd0, v[4]}
                                              + {5'd0, v[6:5], 1'b0};
            end
            3'd3: if (kq) a = 8'd8 + {6'd0, v[6:5]};
            3'd4: if (kq) a = 8'd12 + {6'd0, v[6:5]};
            default: a = 8'd0;
        endcase
        return a;
    endfunction

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    t_state r_state;
    t_fmt   r_fmt;
    logic [6:0]  r_fill;
    logic [15:0] r_hold;
    logic        r_re;
    logic [2:0]  r_cnt;
    logic [8:0]  r_v;
    logic [LANE_CW-1:0] r_lane;
    logic [1:0]  r_op;
    logic [31:0] r_lanes [LANES];
    logic [31:0] r_d, r_dm;
    logic [7:0]  r_qb, r_hb, r_s0, r_s1, r_s2;
    logic [31:0] r_ma, r_mb, r_aa, r_ab;
    logic [31:0] r_res0, r_res1, r_res2, r_val, r_single;
    // multiplier pipe
    logic [47:0] r_mp;
    logic signed [9:0] r_me;
    logic        r_ms, r_mspec;
    logic [31:0] r_mspecv;
    // subtractor pipe
    logic [26:0] r_ax, r_ay;
    logic [27:0] r_sum;
    logic [7:0]  r_ae;
    logic        r_asg, r_asub, r_aspec;
    logic [31:0] r_aspecv;
    // output register
    logic        r_o_valid;
    t_out        r_o_data;

    // block buffer
    logic [15:0] mem [BUF_DEPTH];
    logic [15:0] r_rdata;
    logic [BUF_AW-1:0] w_rd_addr;
    logic        w_mem_we;

    // ------------------------------------------------------------------
    // control decode
    // ------------------------------------------------------------------
    logic        w_in_fire, w_out_free, w_quant;
    logic [6:0]  w_need, w_fill_nx;
    logic [8:0]  w_nvals;
    logic [1:0]  w_last_op;
    logic [7:0]  w_cap_addr, w_cap_byte, w_rd_byte;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign w_out_free  = !r_o_valid || i_out_ready;
    assign w_quant     = (r_fmt == FMT_Q4_0) || (r_fmt == FMT_Q8_0) || (r_fmt == FMT_Q4_K)
                         || (r_fmt == FMT_Q5_K) || (r_fmt == FMT_Q6_K);
    assign w_need      = block_halves(r_fmt);
    assign w_fill_nx   = r_fill + 7'd1;
    assign w_nvals     = ((r_fmt == FMT_Q4_0) || (r_fmt == FMT_Q8_0)) ? 9'd32 : 9'd256;
    assign w_last_op   = ((r_fmt == FMT_Q4_0) || (r_fmt == FMT_Q8_0)) ? 2'd0 :
                         (r_fmt == FMT_Q6_K) ? 2'd1 : 2'd3;
    assign w_mem_we    = w_in_fire && w_quant && !i_cfg_we;

    assign w_cap_addr  = f_slot(r_fmt, r_v, r_cnt - 3'd1);
    assign w_cap_byte  = w_cap_addr[0] ? r_rdata[15:8] : r_rdata[7:0];

    always_comb begin
        w_rd_byte = f_slot(r_fmt, r_v, r_cnt);
        if (r_state == S_HDR) begin
            if (r_cnt == 3'd0) w_rd_byte = (r_fmt == FMT_Q6_K) ? 8'd208 : 8'd0;
            else               w_rd_byte = 8'd2;
        end
    end
    assign w_rd_addr = w_rd_byte[BUF_AW:1];

    always_ff @(posedge i_clk) begin
        if (w_mem_we) mem[r_fill[BUF_AW-1:0]] <= i_in_data.half_word;
        r_rdata <= mem[w_rd_addr];
    end

    // ------------------------------------------------------------------
    // field unpacking of the captured bytes
    // ------------------------------------------------------------------
    logic [3:0]  w_nib4, w_nibk, w_nib6;
    logic [5:0]  w_sc, w_mn;
    logic [1:0]  w_hi2;
    logic signed [8:0] w_x, w_qk, w_q6;

    always_comb begin
        w_nib4 = r_v[4] ? r_qb[7:4] : r_qb[3:0];
        w_nibk = r_v[5] ? r_qb[7:4] : r_qb[3:0];
        w_nib6 = r_v[6] ? r_qb[7:4] : r_qb[3:0];
        w_hi2  = r_hb[{r_v[6:5], 1'b0} +: 2];
        if (r_fmt == FMT_Q4_0) w_x = 9'sd0 + $signed({5'd0, w_nib4}) - 9'sd8;
        else                   w_x = {r_qb[7], r_qb};
        w_qk = $signed({4'd0, (r_fmt == FMT_Q5_K) && r_hb[r_v[7:5]], w_nibk});
        w_q6 = $signed({3'd0, w_hi2, w_nib6}) - 9'sd32;
        if (r_v[7]) begin
            w_sc = {r_s0[7:6], r_s2[3:0]};
            w_mn = {r_s1[7:6], r_s2[7:4]};
        end else begin
            w_sc = r_s0[5:0];
            w_mn = r_s1[5:0];
        end
    end

    // ------------------------------------------------------------------
    // float multiply, stage one: specials and raw product
    // ------------------------------------------------------------------
    logic        w_ma_nan, w_mb_nan, w_ma_inf, w_mb_inf, w_ma_zero, w_mb_zero, w_m_sg;
    logic        w_m_spec;
    logic [31:0] w_m_specv;
    logic [47:0] w_m_prod;
    logic signed [9:0] w_m_exp;

    always_comb begin
        w_ma_nan  = (r_ma[30:23] == 8'hFF) && (r_ma[22:0] != 23'd0);
        w_mb_nan  = (r_mb[30:23] == 8'hFF) && (r_mb[22:0] != 23'd0);
        w_ma_inf  = (r_ma[30:23] == 8'hFF) && (r_ma[22:0] == 23'd0);
        w_mb_inf  = (r_mb[30:23] == 8'hFF) && (r_mb[22:0] == 23'd0);
        w_ma_zero = (r_ma[30:23] == 8'h00);
        w_mb_zero = (r_mb[30:23] == 8'h00);
        w_m_sg    = r_ma[31] ^ r_mb[31];
        w_m_spec  = 1'b1;
        priority if (w_ma_nan)                w_m_specv = r_ma | F32_QUIET_BIT;
        else if (w_mb_nan)                    w_m_specv = r_mb | F32_QUIET_BIT;
        else if ((w_ma_inf && w_mb_zero) || (w_mb_inf && w_ma_zero))
                                              w_m_specv = F32_DEFAULT_NAN;
        else if (w_ma_inf || w_mb_inf)        w_m_specv = {w_m_sg, 8'hFF, 23'd0};
        else if (w_ma_zero || w_mb_zero)      w_m_specv = {w_m_sg, 31'd0};
        else begin
            w_m_specv = 32'd0;
            w_m_spec  = 1'b0;
        end
        w_m_prod = {1'b1, r_ma[22:0]} * {1'b1, r_mb[22:0]};
        w_m_exp  = $signed({2'd0, r_ma[30:23]}) + $signed({2'd0, r_mb[30:23]}) - 10'sd127;
    end

    // stage two: normalize and round
    logic [22:0] w_mr_mant;
    logic        w_mr_g, w_mr_st;
    logic signed [9:0] w_mr_e;
    logic [23:0] w_mr_rnd;
    logic [31:0] w_m_res;

    always_comb begin
        if (r_mp[47]) begin
            w_mr_mant = r_mp[46:24];
            w_mr_g    = r_mp[23];
            w_mr_st   = |r_mp[22:0];
            w_mr_e    = r_me + 10'sd1;
        end else begin
            w_mr_mant = r_mp[45:23];
            w_mr_g    = r_mp[22];
            w_mr_st   = |r_mp[21:0];
            w_mr_e    = r_me;
        end
        w_mr_rnd = {1'b0, w_mr_mant} + 24'(w_mr_g && (w_mr_st || w_mr_mant[0]));
        if (w_mr_rnd[23]) w_mr_e = w_mr_e + 10'sd1;
        w_m_res = r_mspec ? r_mspecv : {r_ms, w_mr_e[7:0], w_mr_rnd[22:0]};
    end

    // ------------------------------------------------------------------
    // float subtract a - b, stage one: specials and alignment
    // ------------------------------------------------------------------
    logic [31:0] w_bn, w_ax_op, w_ay_op;
    logic        w_aa_nan, w_ab_nan, w_aa_inf, w_ab_inf, w_aa_zero, w_ab_zero;
    logic        w_a_spec;
    logic [31:0] w_a_specv;
    logic [7:0]  w_adiff;
    logic [26:0] w_ay_ext, w_ay_msk, w_ay_sh;

    always_comb begin
        w_bn      = {~r_ab[31], r_ab[30:0]};
        w_aa_nan  = (r_aa[30:23] == 8'hFF) && (r_aa[22:0] != 23'd0);
        w_ab_nan  = (r_ab[30:23] == 8'hFF) && (r_ab[22:0] != 23'd0);
        w_aa_inf  = (r_aa[30:23] == 8'hFF) && (r_aa[22:0] == 23'd0);
        w_ab_inf  = (r_ab[30:23] == 8'hFF) && (r_ab[22:0] == 23'd0);
        w_aa_zero = (r_aa[30:23] == 8'h00);
        w_ab_zero = (r_ab[30:23] == 8'h00);
        w_a_spec  = 1'b1;
        priority if (w_aa_nan)             w_a_specv = r_aa | F32_QUIET_BIT;
        else if (w_ab_nan)                 w_a_specv = r_ab | F32_QUIET_BIT;
        else if (w_aa_inf && w_ab_inf)     w_a_specv = (r_aa[31] != w_bn[31]) ?
                                                        F32_DEFAULT_NAN : r_aa;
        else if (w_aa_inf)                 w_a_specv = r_aa;
        else if (w_ab_inf)                 w_a_specv = w_bn;
        else if (w_aa_zero && w_ab_zero)   w_a_specv = {r_aa[31] & w_bn[31], 31'd0};
        else if (w_aa_zero)                w_a_specv = w_bn;
        else if (w_ab_zero)                w_a_specv = r_aa;
        else begin
            w_a_specv = 32'd0;
            w_a_spec  = 1'b0;
        end
        if (r_aa[30:0] >= w_bn[30:0]) begin
            w_ax_op = r_aa;
            w_ay_op = w_bn;
        end else begin
            w_ax_op = w_bn;
            w_ay_op = r_aa;
        end
        w_adiff  = w_ax_op[30:23] - w_ay_op[30:23];
        w_ay_ext = {1'b1, w_ay_op[22:0], 3'd0};
        w_ay_msk = (27'd1 << w_adiff[4:0]) - 27'd1;
        if (w_adiff >= 8'd27) begin
            w_ay_sh = 27'd1;
        end else begin
            w_ay_sh    = w_ay_ext >> w_adiff[4:0];
            w_ay_sh[0] = w_ay_sh[0] | (|(w_ay_ext & w_ay_msk));
        end
    end

    // stage three: normalize and round
    logic [4:0]  w_lz_p;
    logic [26:0] w_an;
    logic signed [9:0] w_an_e;
    logic [23:0] w_an_rnd;
    logic [31:0] w_a_res;

    always_comb begin
        w_lz_p = 5'd0;
        for (int k = 0; k < 27; k++) begin
            if (r_sum[k]) w_lz_p = 5'(k);
        end
        if (r_sum[27]) begin
            w_an   = {r_sum[27:2], r_sum[1] | r_sum[0]};
            w_an_e = $signed({2'd0, r_ae}) + 10'sd1;
        end else begin
            w_an   = r_sum[26:0] << (5'd26 - w_lz_p);
            w_an_e = $signed({2'd0, r_ae}) - $signed({5'd0, 5'd26 - w_lz_p});
        end
        w_an_rnd = {1'b0, w_an[25:3]} + 24'(w_an[2] && ((|w_an[1:0]) || w_an[3]));
        if (w_an_rnd[23]) w_an_e = w_an_e + 10'sd1;
        if (r_aspec)              w_a_res = r_aspecv;
        else if (r_sum == 28'd0)  w_a_res = 32'd0;
        else                      w_a_res = {r_asg, w_an_e[7:0], w_an_rnd[22:0]};
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fmt     <= FMT_Q4_0;
            r_fill    <= 7'd0;
            r_hold    <= 16'd0;
            r_o_valid <= 1'b0;
            r_cnt     <= 3'd0;
            r_v       <= 9'd0;
            r_lane    <= '0;
            r_op      <= 2'd0;
        end else begin
            if (r_o_valid && i_out_ready) r_o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_cfg_we) begin
                        r_fmt  <= t_fmt'(i_cfg_data);
                        r_fill <= 7'd0;
                        r_hold <= 16'd0;
                    end else if (w_in_fire) begin
                        r_re <= i_in_data.row_end;
                        if (w_quant) begin
                            if (w_fill_nx < w_need) begin
                                r_fill <= i_in_data.row_end ? 7'd0 : w_fill_nx;
                            end else begin
                                r_fill  <= 7'd0;
                                r_v     <= 9'd0;
                                r_lane  <= '0;
                                r_cnt   <= 3'd0;
                                r_state <= S_HDR;
                            end
                        end else if (r_fmt == FMT_F16) begin
                            r_single <= f_h2f(i_in_data.half_word);
                            r_state  <= S_SINGLE;
                        end else if (r_fmt == FMT_BF16) begin
                            r_single <= {i_in_data.half_word, 16'd0};
                            r_state  <= S_SINGLE;
                        end else if (r_fill == 7'd0) begin
                            // f32 low half first
                            if (!i_in_data.row_end) begin
                                r_hold <= i_in_data.half_word;
                                r_fill <= 7'd1;
                            end
                        end else begin
                            r_single <= {i_in_data.half_word, r_hold};
                            r_fill   <= 7'd0;
                            r_hold   <= 16'd0;
                            r_state  <= S_SINGLE;
                        end
                    end
                end
                S_SINGLE: begin
                    if (w_out_free) begin
                        r_o_valid                <= 1'b1;
                        r_o_data.lane_zero       <= r_single;
                        r_o_data.lane_one        <= 32'd0;
                        r_o_data.lane_two        <= 32'd0;
                        r_o_data.lane_three      <= 32'd0;
                        r_o_data.lanes_valid     <= 3'd1;
                        r_o_data.block_last      <= 1'b1;
                        r_o_data.row_last        <= r_re;
                        r_state                  <= S_IDLE;
                    end
                end
                S_HDR: begin
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'd1) r_d <= f_h2f(r_rdata);
                    if (r_cnt == 3'd2) begin
                        r_dm    <= f_h2f(r_rdata);
                        r_cnt   <= 3'd0;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_cnt <= r_cnt + 3'd1;
                    unique case (r_cnt)
                        3'd1:    r_qb <= w_cap_byte;
                        3'd2:    r_hb <= w_cap_byte;
                        3'd3:    r_s0 <= w_cap_byte;
                        3'd4:    r_s1 <= w_cap_byte;
                        3'd5: begin
                            r_s2    <= w_cap_byte;
                            r_op    <= 2'd0;
                            r_state <= S_OPSET;
                        end
                        default: ;
                    endcase
                end
                S_OPSET: begin
                    r_state <= S_M1;
                    unique case (r_op)
                        2'd0: begin
                            if ((r_fmt == FMT_Q4_0) || (r_fmt == FMT_Q8_0)) begin
                                r_ma <= f_i2f(w_x);
                                r_mb <= r_d;
                            end else if (r_fmt == FMT_Q6_K) begin
                                r_ma <= r_d;
                                r_mb <= f_i2f({r_s0[7], r_s0});
                            end else begin
                                r_ma <= r_d;
                                r_mb <= f_i2f({3'd0, w_sc});
                            end
                        end
                        2'd1: begin
                            r_ma <= r_res0;
                            r_mb <= f_i2f((r_fmt == FMT_Q6_K) ? w_q6 : w_qk);
                        end
                        2'd2: begin
                            r_ma <= r_dm;
                            r_mb <= f_i2f({3'd0, w_mn});
                        end
                        2'd3: begin
                            r_aa    <= r_res1;
                            r_ab    <= r_res2;
                            r_state <= S_A1;
                        end
                    endcase
                end
                S_M1: begin
                    r_mp     <= w_m_prod;
                    r_me     <= w_m_exp;
                    r_ms     <= w_m_sg;
                    r_mspec  <= w_m_spec;
                    r_mspecv <= w_m_specv;
                    r_state  <= S_M2;
                end
                S_M2: begin
                    unique case (r_op)
                        2'd0:    r_res0 <= w_m_res;
                        2'd1:    r_res1 <= w_m_res;
                        default: r_res2 <= w_m_res;
                    endcase
                    if (r_op == w_last_op) begin
                        r_val   <= w_m_res;
                        r_state <= S_LANE;
                    end else begin
                        r_op    <= r_op + 2'd1;
                        r_state <= S_OPSET;
                    end
                end
                S_A1: begin
                    r_ax     <= {1'b1, w_ax_op[22:0], 3'd0};
                    r_ay     <= w_ay_sh;
                    r_ae     <= w_ax_op[30:23];
                    r_asg    <= w_ax_op[31];
                    r_asub   <= w_ax_op[31] ^ w_ay_op[31];
                    r_aspec  <= w_a_spec;
                    r_aspecv <= w_a_specv;
                    r_state  <= S_A2;
                end
                S_A2: begin
                    r_sum   <= r_asub ? ({1'b0, r_ax} - {1'b0, r_ay})
                                      : ({1'b0, r_ax} + {1'b0, r_ay});
                    r_state <= S_A3;
                end
                S_A3: begin
                    r_val   <= w_a_res;
                    r_state <= S_LANE;
                end
                S_LANE: begin
                    r_lanes[r_lane[LANE_IW-1:0]] <= r_val;
                    r_lane <= r_lane + LANE_CW'(1);
                    r_v    <= r_v + 9'd1;
                    r_cnt  <= 3'd0;
                    if ((r_lane + LANE_CW'(1) == LANE_CW'(LANES)) || (r_v + 9'd1 == w_nvals))
                        r_state <= S_OUT;
                    else
                        r_state <= S_RD;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_o_valid            <= 1'b1;
                        r_o_data.lane_zero   <= r_lanes[0];
                        r_o_data.lane_one    <= (r_lane > LANE_CW'(1)) ? r_lanes[1] : 32'd0;
                        r_o_data.lane_two    <= (r_lane > LANE_CW'(2)) ? r_lanes[2] : 32'd0;
                        r_o_data.lane_three  <= (r_lane > LANE_CW'(3)) ? r_lanes[3] : 32'd0;
                        r_o_data.lanes_valid <= 3'(r_lane);
                        r_o_data.block_last  <= (r_v == w_nvals);
                        r_o_data.row_last    <= (r_v == w_nvals) && r_re;
                        r_lane               <= '0;
                        r_cnt                <= 3'd0;
                        r_state              <= (r_v == w_nvals) ? S_IDLE : S_RD;
                    end
                end
            endcase
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_data;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_fill_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < w_need)
        else $error("fill position beyond block size");

    a_lanes_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.lanes_valid >= 3'd1) &&
                        (o_out_data.lanes_valid <= 3'(LANES)))
        else $error("lane count out of range");

    a_row_implies_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.row_last) |-> o_out_data.block_last)
        else $error("row end flagged inside a block");

    a_value_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> (r_v < w_nvals) && (r_lane < LANE_CW'(LANES)))
        else $error("value index past end of block");

    a_out_loaded_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !w_out_free) |=> (r_state == S_OUT))
        else $error("left output state while output register busy");

endmodule

// ===== bench/dequant_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dequant_monitor
// watches both channels, predicts float32 lane results and compares them
// ----------------------------------------------------------------------------
module dequant_monitor
    import qwd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic [2:0] i_cfg_data,
    input  logic i_in_valid,
    input  logic i_in_ready,
    input  t_in  i_in_data,
    input  logic i_out_valid,
    input  logic i_out_ready,
    input  t_out i_out_data,
    output int   o_errors,
    output int   o_pending
);

    localparam logic [31:0] POS_INF = 32'h7F80_0000;

    t_out        lane_results_q[$];
    int          mismatches;
    t_fmt        cur_fmt;
    int          fill_count;
    logic [15:0] low_hold;
    logic [15:0] blk_mem[BUF_DEPTH];
    logic [31:0] vals[256];

    assign o_errors  = mismatches;
    assign o_pending = lane_results_q.size();

    // ---------------- float helpers ----------------
    function automatic bit is_nan(logic [31:0] x);
        return x[30:23] == 8'hFF && x[22:0] != 0;
    endfunction

    function automatic bit is_inf(logic [31:0] x);
        return x[30:0] == POS_INF[30:0];
    endfunction

    function automatic bit is_zero(logic [31:0] x);
        return x[30:0] == 0;
    endfunction

    function automatic real f32_to_real(logic [31:0] x);
        real mag;
        logic [10:0] dexp;
        if (x[30:23] == 0) begin
            mag = real'(x[22:0]) * 2.0 ** (-149);
        end else begin
            dexp = {3'b0, x[30:23]} + 11'd896;
            mag  = $bitstoreal({1'b0, dexp, x[22:0], 29'b0});
        end
        return x[31] ? -mag : mag;
    endfunction

    // round a nonzero double to binary32, nearest even
    function automatic logic [31:0] real_to_f32(real r);
        logic [63:0] b, sig, kept, rest, half;
        int fe, sh;
        b   = $realtobits(r);
        fe  = int'(b[62:52]) - 1023 + 127;
        sig = {11'b0, 1'b1, b[51:0]};
        sh  = (fe >= 1) ? 29 : 30 - fe;
        if (sh >= 64)
            return {b[63], 31'b0};
        kept = sig >> sh;
        rest = sig & ((64'd1 << sh) - 1);
        half = 64'd1 << (sh - 1);
        if (rest > half || (rest == half && kept[0]))
            kept = kept + 1;
        if (fe >= 1) begin
            if (kept[24]) begin
                kept = kept >> 1;
                fe++;
            end
            if (fe >= 255)
                return {b[63], POS_INF[30:0]};
            return {b[63], fe[7:0], kept[22:0]};
        end
        return {b[63], kept[30:0]};
    endfunction

    function automatic logic [31:0] int_to_f32(int v);
        if (v == 0)
            return 32'h0;
        return real_to_f32(real'(v));
    endfunction

    function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
        real p;
        if (is_nan(a))
            return a | F32_QUIET_BIT;
        if (is_nan(b))
            return b | F32_QUIET_BIT;
        if ((is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b)))
            return F32_DEFAULT_NAN;
        if (is_inf(a) || is_inf(b))
            return {a[31] ^ b[31], POS_INF[30:0]};
        p = f32_to_real(a) * f32_to_real(b);
        if (p == 0.0)
            return {a[31] ^ b[31], 31'b0};
        return real_to_f32(p);
    endfunction

    function automatic logic [31:0] fp_sub(logic [31:0] a, logic [31:0] b);
        real d;
        if (is_nan(a))
            return a | F32_QUIET_BIT;
        if (is_nan(b))
            return b | F32_QUIET_BIT;
        if (is_inf(a) && is_inf(b))
            return (a[31] == b[31]) ? F32_DEFAULT_NAN : a;
        if (is_inf(a))
            return a;
        if (is_inf(b))
            return b ^ 32'h8000_0000;
        d = f32_to_real(a) - f32_to_real(b);
        if (d == 0.0)
            return (a == 32'h8000_0000 && b == 32'h0) ? 32'h8000_0000 : 32'h0;
        return real_to_f32(d);
    endfunction

    function automatic logic [31:0] half_to_f32(logic [15:0] h);
        logic [31:0] sgn;
        int e, shifts;
        logic [10:0] m;
        sgn = {h[15], 31'b0};
        e = h[14:10];
        m = {1'b0, h[9:0]};
        shifts = 0;
        if (e == 0) begin
            if (m == 0)
                return sgn;
            while (!m[10]) begin
                m = m << 1;
                shifts++;
            end
            e = 1 + 112 - shifts;
        end else if (e == 31) begin
            return sgn | POS_INF | {9'b0, m[9:0], 13'b0};
        end else begin
            e = e + 112;
        end
        return sgn | {1'b0, e[7:0], m[9:0], 13'b0};
    endfunction

    // ---------------- block access ----------------
    function automatic logic [7:0] blk_byte(int k);
        logic [15:0] w;
        w = blk_mem[(k >> 1) % BUF_DEPTH];
        return k[0] ? w[15:8] : w[7:0];
    endfunction

    function automatic logic [31:0] blk_half(int k);
        return half_to_f32({blk_byte(k + 1), blk_byte(k)});
    endfunction

    function automatic int halves_per_block(t_fmt f);
        case (f)
            FMT_Q4_0: return 9;
            FMT_Q8_0: return 17;
            FMT_Q4_K: return 72;
            FMT_Q5_K: return 88;
            FMT_Q6_K: return 105;
            FMT_F32:  return 2;
            default:  return 1;
        endcase
    endfunction

    // fills vals from a complete block, returns the value count
    function automatic int decode_block(t_fmt f);
        logic [31:0] s, d, dm, d1, d2, m1, m2, ds;
        logic [7:0]  b, h, hb;
        int sc[8], mn[8];
        int qbase, lo, hi, is, k, q;
        case (f)
            FMT_Q4_0: begin
                s = blk_half(0);
                for (int j = 0; j < 16; j++) begin
                    b = blk_byte(2 + j);
                    vals[j]      = fp_mul(int_to_f32(int'(b[3:0]) - 8), s);
                    vals[j + 16] = fp_mul(int_to_f32(int'(b[7:4]) - 8), s);
                end
                return 32;
            end
            FMT_Q8_0: begin
                s = blk_half(0);
                for (int j = 0; j < 32; j++)
                    vals[j] = fp_mul(int_to_f32(int'($signed(blk_byte(2 + j)))), s);
                return 32;
            end
            FMT_Q4_K, FMT_Q5_K: begin
                d  = blk_half(0);
                dm = blk_half(2);
                qbase = (f == FMT_Q4_K) ? 16 : 48;
                // six-bit scales and mins; the upper four take their low bits from the last four bytes
                for (int i = 0; i < 4; i++) begin
                    sc[i]     = blk_byte(4 + i) & 63;
                    sc[i + 4] = (blk_byte(12 + i) & 8'h0F) | ((blk_byte(4 + i) >> 6) << 4);
                    mn[i]     = blk_byte(8 + i) & 63;
                    mn[i + 4] = (blk_byte(12 + i) >> 4) | ((blk_byte(8 + i) >> 6) << 4);
                end
                for (int j = 0; j < 4; j++) begin
                    d1 = fp_mul(d, int_to_f32(sc[2 * j]));
                    d2 = fp_mul(d, int_to_f32(sc[2 * j + 1]));
                    m1 = fp_mul(dm, int_to_f32(mn[2 * j]));
                    m2 = fp_mul(dm, int_to_f32(mn[2 * j + 1]));
                    for (int l = 0; l < 32; l++) begin
                        b  = blk_byte(qbase + 32 * j + l);
                        lo = b[3:0];
                        hi = b[7:4];
                        if (f == FMT_Q5_K) begin
                            h  = blk_byte(16 + l);
                            lo += h[2 * j] ? 16 : 0;
                            hi += h[2 * j + 1] ? 16 : 0;
                        end
                        vals[64 * j + l]      = fp_sub(fp_mul(d1, int_to_f32(lo)), m1);
                        vals[64 * j + l + 32] = fp_sub(fp_mul(d2, int_to_f32(hi)), m2);
                    end
                end
                return 256;
            end
            default: begin
                d = blk_half(208);
                for (int n = 0; n < 256; n += 128) begin
                    for (int l = 0; l < 32; l++) begin
                        is = n / 16 + l / 16;
                        b  = blk_byte(n / 2 + l);
                        hb = blk_byte(n / 2 + l + 32);
                        h  = blk_byte(128 + n / 4 + l);
                        for (k = 0; k < 4; k++) begin
                            case (k)
                                0: q = int'({h[1:0], b[3:0]});
                                1: q = int'({h[3:2], hb[3:0]});
                                2: q = int'({h[5:4], b[7:4]});
                                default: q = int'({h[7:6], hb[7:4]});
                            endcase
                            ds = fp_mul(d, int_to_f32(int'($signed(blk_byte(192 + is + 2 * k)))));
                            vals[n + l + 32 * k] = fp_mul(ds, int_to_f32(q - 32));
                        end
                    end
                end
                return 256;
            end
        endcase
    endfunction

    task automatic queue_lane_results(int nv, logic re);
        t_out r;
        int nres, left;
        nres = (nv + LANES - 1) / LANES;
        for (int i = 0; i < nres; i++) begin
            left = nv - i * LANES;
            if (left > LANES)
                left = LANES;
            r = '0;
            r.lane_zero  = vals[i * LANES];
            r.lane_one   = (left > 1) ? vals[i * LANES + 1] : 32'h0;
            r.lane_two   = (left > 2) ? vals[i * LANES + 2] : 32'h0;
            r.lane_three = (left > 3) ? vals[i * LANES + 3] : 32'h0;
            r.lanes_valid = left[2:0];
            r.block_last  = (i + 1 == nres);
            r.row_last    = (i + 1 == nres) && re;
            lane_results_q.push_back(r);
        end
    endtask

    task automatic predict_beat(t_in d);
        int need;
        if (cur_fmt == FMT_F16 || cur_fmt == FMT_BF16 || cur_fmt == FMT_F32) begin
            if (cur_fmt == FMT_F16) begin
                vals[0] = half_to_f32(d.half_word);
            end else if (cur_fmt == FMT_BF16) begin
                vals[0] = {d.half_word, 16'h0};
            end else if (fill_count == 0) begin
                // low half; a row end here drops it
                if (!d.row_end) begin
                    low_hold   = d.half_word;
                    fill_count = 1;
                end
                return;
            end else begin
                vals[0]    = {d.half_word, low_hold};
                fill_count = 0;
                low_hold   = '0;
            end
            queue_lane_results(1, d.row_end);
            return;
        end
        need = halves_per_block(cur_fmt);
        if (fill_count >= need)
            fill_count = 0;
        blk_mem[fill_count % BUF_DEPTH] = d.half_word;
        fill_count++;
        if (fill_count < need) begin
            if (d.row_end)
                fill_count = 0;
            return;
        end
        fill_count = 0;
        queue_lane_results(decode_block(cur_fmt), d.row_end);
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            cur_fmt    = FMT_Q4_0;
            fill_count = 0;
            low_hold   = '0;
            mismatches = 0;
            lane_results_q.delete();
        end else begin
            if (i_cfg_we) begin
                cur_fmt    = t_fmt'(i_cfg_data);
                fill_count = 0;
                low_hold   = '0;
            end
            if (i_in_valid && i_in_ready)
                predict_beat(i_in_data);
            if (i_out_valid && i_out_ready) begin
                if (lane_results_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result beat %h", i_out_data);
                    mismatches++;
                end else begin
                    want = lane_results_q.pop_front();
                    if (want.lane_zero !== i_out_data.lane_zero
                        || want.lane_one !== i_out_data.lane_one
                        || want.lane_two !== i_out_data.lane_two
                        || want.lane_three !== i_out_data.lane_three
                        || want.lanes_valid !== i_out_data.lanes_valid
                        || want.block_last !== i_out_data.block_last
                        || want.row_last !== i_out_data.row_last) begin
                        if (mismatches < 10)
                            $display("mismatch fmt %0d: expected %h %h %h %h n%0d b%0d r%0d, got %h %h %h %h n%0d b%0d r%0d",
                                cur_fmt, want.lane_zero, want.lane_one, want.lane_two,
                                want.lane_three, want.lanes_valid, want.block_last,
                                want.row_last, i_out_data.lane_zero, i_out_data.lane_one,
                                i_out_data.lane_two, i_out_data.lane_three,
                                i_out_data.lanes_valid, i_out_data.block_last,
                                i_out_data.row_last);
                        mismatches++;
                    end
                end
            end
        end
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the quantized weight dequantizer
// ----------------------------------------------------------------------------
// Streams halfwords through every format: directed special values for the
// scalar formats and one full q4_0 block, then random phases of complete
// blocks with random content, broken rows and scalar runs. The monitor
// predicts every result beat and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import qwd_pkg::*;

    localparam int IDLE_LIMIT = 8000;
    localparam int DRAIN_WAIT = 40;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [2:0] i_cfg_data;
    logic i_in_valid;
    logic o_in_ready;
    t_in  i_in_data;
    logic o_out_valid;
    logic i_out_ready;
    t_out o_out_data;

    int errors;
    int pending;
    int beats_in;
    int idle_cycles;
    bit sender_busy;    // no-idle stretch on the input side

    quantized_weight_dequantizer u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    dequant_monitor u_monitor (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .i_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_out_data (o_out_data),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // watchdog: cycles with no beat on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (i_in_valid && o_in_ready)
            beats_in <= beats_in + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver: one long hold-off while input keeps coming, then random stalls
    initial begin
        bit held;
        int g;
        held = 0;
        i_out_ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (!held && beats_in >= 30) begin
                held = 1;
                i_out_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end
            g = ($urandom_range(0, 3) == 0) ? 0 : pick_gap();
            if (g > 0) begin
                i_out_ready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
        end
    end

    // one input beat; valid stays up after acceptance until the next call
    task automatic send_beat(logic [15:0] hw, logic re);
        int g;
        g = sender_busy ? 0 : pick_gap();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{half_word: hw, row_end: re};
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        // a partial block may still be buffered with nothing expected
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic set_format(t_fmt f);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= f;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // random phase: full blocks with random content, some broken rows
    task automatic block_phase(t_fmt f, int nblocks);
        int need, cut;
        need = block_halves(f);
        set_format(f);
        sender_busy = ($urandom_range(0, 2) == 0);
        for (int b = 0; b < nblocks; b++) begin
            if ($urandom_range(0, 4) == 0) begin
                // row end inside a block drops the partial block
                cut = $urandom_range(1, need - 1);
                for (int i = 0; i < cut; i++)
                    send_beat($urandom_range(0, 65535), i == cut - 1);
            end
            for (int i = 0; i < need; i++)
                send_beat($urandom_range(0, 65535),
                          (i == need - 1) ? $urandom_range(0, 1) : 1'b0);
        end
    endtask

    task automatic scalar_phase(t_fmt f, int count);
        set_format(f);
        sender_busy = ($urandom_range(0, 2) == 0);
        for (int i = 0; i < count; i++)
            send_beat($urandom_range(0, 65535), $urandom_range(0, 3) == 0);
    endtask

    initial begin
        logic [15:0] f16_specials[10];
        f16_specials = '{16'h0000, 16'h8000, 16'h0001, 16'h03FF, 16'h7C00,
                         16'hFC00, 16'h7E01, 16'h7BFF, 16'h3C00, 16'h8200};
        sender_busy = 0;
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_data <= FMT_Q4_0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        idle_cycles <= 0;
        beats_in    <= 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // f16: zeros, denormals, infinities, nan, largest finite
        set_format(FMT_F16);
        foreach (f16_specials[i])
            send_beat(f16_specials[i], i[0]);
        // bf16 is a plain shift
        set_format(FMT_BF16);
        send_beat(16'hFFFF, 1'b1);
        send_beat(16'h7F80, 1'b0);
        // f32: low half with row end is dropped, then whole pairs
        set_format(FMT_F32);
        send_beat(16'hFFFF, 1'b1);
        send_beat(16'h0000, 1'b0);
        send_beat(16'h8000, 1'b1);
        send_beat(16'hFFFF, 1'b0);
        send_beat(16'h7FFF, 1'b0);
        // q4_0 block: scale 1.0, nibbles at both extremes
        set_format(FMT_Q4_0);
        send_beat(16'h3C00, 1'b0);
        for (int i = 0; i < 8; i++)
            send_beat(i[0] ? 16'hFFFF : 16'h0F00, i == 7);

        // random phases over all formats, both ends of the register range
        block_phase(FMT_Q4_0, 3);
        block_phase(FMT_Q8_0, 2);
        scalar_phase(FMT_F16, 20);
        scalar_phase(FMT_BF16, 15);
        scalar_phase(FMT_F32, 24);
        block_phase(FMT_Q6_K, 1);
        block_phase(FMT_Q4_K, 1);
        block_phase(FMT_Q5_K, 1);
        block_phase(FMT_Q8_0, 1);
        scalar_phase(FMT_F32, 10);
        block_phase(FMT_Q4_0, 2);

        wait_drained();
        if (errors == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
design/qwd_pkg.sv
design/quantized_weight_dequantizer.sv
bench/dequant_monitor.sv
bench/testbench.sv
